// ===== src/char_class_to_bitmap_parser_macros.svh =====
// Assertion macros used by the checker file.
`ifndef CHAR_CLASS_TO_BITMAP_PARSER_MACROS_SVH
`define CHAR_CLASS_TO_BITMAP_PARSER_MACROS_SVH

// Clocked check that is ignored while reset is asserted.
`define CCTB_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked check that is also evaluated during reset.
`define CCTB_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== src/cctb_pkg.sv =====
package cctb_pkg;

  // Status reported with every word of a finished set.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_UNBAL = 2'd1,
    ST_BRACE = 2'd2
  } status_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_text;
  } in_t;

  typedef struct packed {
    logic [63:0] set_word;
    logic [1:0]  word_index;
    logic        last_word;
    logic [1:0]  status;
  } out_t;

  // Finished set handed from the parser to the output buffer.
  typedef struct packed {
    logic         valid;
    logic [255:0] set;
    status_e      status;
  } fin_t;

  localparam int unsigned WordW    = 64;
  localparam int unsigned NumWords = 4;
  localparam logic [1:0]  LastIdx  = 2'(NumWords - 1);

  localparam logic [7:0] ChStar    = 8'h2A;
  localparam logic [7:0] ChDot     = 8'h2E;
  localparam logic [7:0] ChLBrace  = 8'h7B;
  localparam logic [7:0] ChRBrace  = 8'h7D;

endpackage

// ===== src/char_class_to_bitmap_parser.sv =====
// Character-class bitmap parser. Each accepted request carries one byte of a
// character-class text; the block takes one byte per clock cycle, and the
// whole parse step for a byte (escapes, hex pairs, ranges, bracket depth and
// the class escapes) is done in the cycle it is accepted, with the 256-way
// range fill computed in parallel. The byte marked end_of_text closes the
// text: the finished 256-bit set and its status are copied into an output
// buffer and the parser returns to its reset state at the same edge, so the
// next text may start in the very next cycle. The buffer sends the set as
// four 64-bit words, word 0 first, one per cycle when the consumer does not
// stall. Bytes that do not end a text are always accepted, even while a set
// drains; a final byte is held off while an earlier set still has words
// waiting, unless its last word is taken in that same cycle, so back-to-back
// texts of four or more bytes run at one byte per cycle when the consumer
// does not stall. A status other than ok comes with all-zero words.
module char_class_to_bitmap_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cctb_pkg::in_t  in_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cctb_pkg::out_t out_o
);
  import cctb_pkg::*;

  fin_t         fin;
  logic         in_accept;
  logic         drain_done;

  // Output buffer for one finished set.
  logic         busy_q, busy_d;
  logic [1:0]   cnt_q, cnt_d;
  logic [255:0] set_q, set_d;
  status_e      status_q, status_d;

  // The buffer frees up in the same cycle that its last word is taken.
  assign drain_done = busy_q && cnt_q == LastIdx && !out_stall_i;
  assign in_stall_o = busy_q && !drain_done && in_i.end_of_text;
  assign in_accept  = in_valid_i && !in_stall_o;

  cctb_parse u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .item_i   (in_i),
    .fin_o    (fin)
  );

  always_comb begin
    busy_d   = busy_q;
    cnt_d    = cnt_q;
    set_d    = set_q;
    status_d = status_q;
    if (fin.valid) begin
      // A failed parse is reported with an empty set.
      busy_d   = 1'b1;
      cnt_d    = '0;
      set_d    = (fin.status == ST_OK) ? fin.set : '0;
      status_d = fin.status;
    end else if (busy_q && !out_stall_i) begin
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == LastIdx) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    set_q    <= set_d;
    status_q <= status_d;
  end

  assign out_valid_o      = busy_q;
  assign out_o.set_word   = set_q[{cnt_q, 6'd0} +: WordW];
  assign out_o.word_index = cnt_q;
  assign out_o.last_word  = cnt_q == LastIdx;
  assign out_o.status     = status_q;

endmodule

// ===== src/cctb_parse.sv =====
module cctb_parse (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  cctb_pkg::in_t item_i,
  output cctb_pkg::fin_t fin_o
);
  import cctb_pkg::*;

  localparam logic [1:0] HexNone   = 2'd0;
  localparam logic [1:0] HexSecond = 2'd1;
  localparam logic [1:0] HexFirst  = 2'd2;
  localparam logic [1:0] HexSkip   = 2'd3;

  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChLBrack = 8'h5B;
  localparam logic [7:0] ChRBrack = 8'h5D;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChCaret  = 8'h5E;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChA      = 8'h61;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChV      = 8'h76;
  localparam logic [7:0] ChS      = 8'h73;
  localparam logic [7:0] ChD      = 8'h64;
  localparam logic [7:0] ChW      = 8'h77;
  localparam logic [7:0] ChX      = 8'h78;

  localparam logic [255:0] SpaceMask =
    {64'h0, 64'h0, 64'h0, 64'h0000_0001_0000_3E00};
  localparam logic [255:0] DigitMask =
    {64'h0, 64'h0, 64'h0, 64'h03FF_0000_0000_0000};
  localparam logic [255:0] WordMask  =
    {64'h0, 64'h0, 64'h07FF_FFFE_87FF_FFFE, 64'h03FF_0000_0000_0000};
  localparam logic [7:0] DepthMax = 8'h7F;
  localparam logic [7:0] DepthMin = 8'h80;
  localparam logic [7:0] NewlineCode = 8'd10;

  // Returns {valid, digit} for an ASCII hex digit.
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39)      r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  logic [255:0] bits_q, bits_d;
  logic         esc_q, esc_d;
  logic         rng_q, rng_d;
  logic [7:0]   rng_lo_q, rng_lo_d;
  logic [7:0]   prev_q, prev_d;
  logic         inv_q, inv_d;
  logic [7:0]   depth_q, depth_d;
  logic [1:0]   hl_q, hl_d;
  logic [7:0]   hv_q, hv_d;
  logic         start_q, start_d;
  logic         brace_q, brace_d;

  logic [7:0]   c;
  logic         last;
  logic [4:0]   hx;
  logic         add_en;
  logic [7:0]   add_code;
  logic [255:0] cls_mask;
  logic [255:0] add_mask;
  logic         whole_star, whole_dot;

  assign c    = item_i.char_code;
  assign last = item_i.end_of_text;
  assign hx   = hex_of(c);

  always_comb begin
    esc_d    = esc_q;
    rng_d    = rng_q;
    rng_lo_d = rng_lo_q;
    prev_d   = prev_q;
    inv_d    = inv_q;
    depth_d  = depth_q;
    hl_d     = hl_q;
    hv_d     = hv_q;
    start_d  = 1'b0;
    brace_d  = brace_q | (start_q && c == ChLBrace);
    add_en   = 1'b0;
    add_code = c;
    cls_mask = '0;

    if (hl_q != HexNone) begin
      if (hl_q == HexFirst) begin
        if (hx[4]) begin
          hv_d = {4'd0, hx[3:0]};
          hl_d = HexSecond;
        end else begin
          hv_d = '0;
          hl_d = HexSkip;
        end
        if (last) begin
          hl_d     = HexNone;
          add_en   = 1'b1;
          add_code = hv_d;
        end
      end else begin
        if (hl_q == HexSecond && hx[4]) begin
          hv_d = {hv_q[3:0], hx[3:0]};
        end
        hl_d     = HexNone;
        add_en   = 1'b1;
        add_code = hv_d;
      end
    end else if (esc_q) begin
      esc_d  = 1'b0;
      add_en = 1'b1;
      case (c)
        ChLBrace, ChRBrace: esc_d = 1'b1;
        ChN: add_code = 8'd10;
        ChR: add_code = 8'd13;
        ChT: add_code = 8'd9;
        ChA: add_code = 8'd7;
        ChB: add_code = 8'd8;
        ChF: add_code = 8'd12;
        ChV: add_code = 8'd11;
        ChS: begin
          add_en   = 1'b0;
          cls_mask = SpaceMask;
        end
        ChD: begin
          add_en   = 1'b0;
          cls_mask = DigitMask;
        end
        ChW: begin
          add_en   = 1'b0;
          cls_mask = WordMask;
        end
        ChX: begin
          hv_d     = '0;
          add_en   = last;
          add_code = '0;
          if (!last) hl_d = HexFirst;
        end
        default: ;
      endcase
    end else begin
      case (c)
        ChBslash: esc_d = 1'b1;
        ChLBrack: if (depth_q != DepthMax) depth_d = depth_q + 8'd1;
        ChRBrack: if (depth_q != DepthMin) depth_d = depth_q - 8'd1;
        ChDash: begin
          rng_d    = 1'b1;
          rng_lo_d = prev_q;
        end
        ChCaret: inv_d = 1'b1;
        default: add_en = 1'b1;
      endcase
    end

    // A member sets its own bit and closes any open range on its code.
    add_mask = '0;
    if (add_en) begin
      for (int i = 0; i < 256; i++) begin
        add_mask[i] = (8'(i) == add_code) ||
                      (rng_q && 8'(i) >= rng_lo_q && 8'(i) <= add_code);
      end
      rng_d  = 1'b0;
      prev_d = add_code;
    end
    bits_d = bits_q | cls_mask | add_mask;
  end

  assign whole_star = start_q && last && c == ChStar;
  assign whole_dot  = start_q && last && c == ChDot;

  always_comb begin
    fin_o.valid  = accept_i && last;
    fin_o.set    = inv_d ? ~bits_d : bits_d;
    fin_o.status = ST_OK;
    if (whole_star) begin
      fin_o.set = '1;
    end else if (whole_dot) begin
      fin_o.set = '1;
      fin_o.set[NewlineCode] = 1'b0;
    end else if (brace_d && c == ChRBrace) begin
      fin_o.status = ST_BRACE;
    end else if (depth_d != '0) begin
      fin_o.status = ST_UNBAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q   <= '0;
      esc_q    <= 1'b0;
      rng_q    <= 1'b0;
      rng_lo_q <= '0;
      prev_q   <= '0;
      inv_q    <= 1'b0;
      depth_q  <= '0;
      hl_q     <= HexNone;
      hv_q     <= '0;
      start_q  <= 1'b1;
      brace_q  <= 1'b0;
    end else if (accept_i) begin
      if (last) begin
        bits_q   <= '0;
        esc_q    <= 1'b0;
        rng_q    <= 1'b0;
        rng_lo_q <= '0;
        prev_q   <= '0;
        inv_q    <= 1'b0;
        depth_q  <= '0;
        hl_q     <= HexNone;
        hv_q     <= '0;
        start_q  <= 1'b1;
        brace_q  <= 1'b0;
      end else begin
        bits_q   <= bits_d;
        esc_q    <= esc_d;
        rng_q    <= rng_d;
        rng_lo_q <= rng_lo_d;
        prev_q   <= prev_d;
        inv_q    <= inv_d;
        depth_q  <= depth_d;
        hl_q     <= hl_d;
        hv_q     <= hv_d;
        start_q  <= start_d;
        brace_q  <= brace_d;
      end
    end
  end

endmodule

// ===== src/cctb_checker.sv =====
`include "char_class_to_bitmap_parser_macros.svh"

module cctb_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input cctb_pkg::in_t  in_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input cctb_pkg::out_t out_o
);
  import cctb_pkg::*;

  `CCTB_ASSERT_RST(a_no_out_in_reset, !rst_ni |-> !out_valid_o, "output valid during reset")

  `CCTB_ASSERT(a_first_word_follows, in_valid_i && !in_stall_o && in_i.end_of_text |=> out_valid_o && out_o.word_index == 2'd0, "final byte not followed by word 0")

  `CCTB_ASSERT(a_words_in_order, out_valid_o && !out_stall_i && out_o.word_index != LastIdx |=> out_valid_o && out_o.word_index == $past(out_o.word_index) + 2'd1, "words out of order")

  `CCTB_ASSERT(a_status_per_set, out_valid_o && out_o.word_index != 2'd0 |-> out_o.status == $past(out_o.status), "status changed within a set")

  `CCTB_ASSERT(a_error_empty, out_valid_o && out_o.status != ST_OK |-> out_o.set_word == '0, "error status with nonzero word")

endmodule

bind char_class_to_bitmap_parser cctb_checker u_checker (.*);
